// ===== rtl/kmhv_pkg.sv =====
package kmhv_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_REF_DEFAULT   = 4096;
    localparam int VOTE_BITS_DEFAULT = 16;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register file
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_REF_LEN  = 2'd0;
    localparam logic [1:0] REG_WIN_LEN  = 2'd1;
    localparam logic [1:0] REG_KMER_LEN = 2'd2;

    localparam logic [12:0] REF_LEN_RESET  = 13'd4096;
    localparam logic [12:0] WIN_LEN_RESET  = 13'd1024;
    localparam logic [6:0]  KMER_LEN_RESET = 7'd15;

    // Request codes
    localparam logic REQ_HIT    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic [12:0] ref_length;
        logic [12:0] window_length;
        logic [6:0]  kmer_length;
    } cfg_t;

    typedef struct packed {
        logic is_finish;
        logic vote;
        logic end_valid;
    } cmd_ctrl_t;

    // Memory operations of the back-end read-modify-write pipe
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_INC  = 3'd1,
        OP_DEC  = 3'd2,
        OP_SCAN = 3'd3,
        OP_NORM = 3'd4,
        OP_ZERO = 3'd5
    } op_t;

endpackage

// ===== rtl/kmer_hit_region_voter.sv =====
// kmer_hit_region_voter: counts k-mer seed hits per reference window and
// reports the best window.
//
// Input channel (in_valid/in_ready): one word per seed hit (req_type 0,
// hit_position) or a finish request (req_type 1). Output channel
// (out_valid/out_ready): one word per finish, carrying best_region,
// best_votes, tied_regions and region_len. Hits produce no output word.
// Configuration goes over the APB port: ref_length at 0x0, window_length
// at 0x4, kmer_length at 0x8; write only while the block is idle.
//
// Memory use: a hit takes the back end's single memory read-modify-write
// port for the start edge, then for the end edge of the difference store;
// it skips the end edge when its range runs to the last entry and uses
// no edge when it casts no vote. A finish walks all MAX_REF entries, one
// per cycle, before its result is shown. After every 2^VOTE_BITS voting
// hits in one run the back end folds the difference store into saturated
// counts in a pass over all entries. Reset: the vote store is cleared by
// a pass over all MAX_REF entries; in_ready stays low until it ends.
// A stalled receiver holds the result register; hits keep flowing, and a
// later finish waits until the result is taken.
module kmer_hit_region_voter #(
    parameter int MAX_REF   = kmhv_pkg::MAX_REF_DEFAULT,
    parameter int VOTE_BITS = kmhv_pkg::VOTE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmhv_pkg::ADDR_W-1:0]   paddr,
    input  logic [kmhv_pkg::DATA_W-1:0]   pwdata,
    output logic [kmhv_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [11:0]                   hit_position,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [11:0]                   best_region,
    output logic [15:0]                   best_votes,
    output logic [12:0]                   tied_regions,
    output logic [12:0]                   region_len
);
    import kmhv_pkg::*;

    localparam int AW = $clog2(MAX_REF);
    localparam int CW = $clog2(MAX_REF + 1);
    localparam int CTRL_W = $bits(cmd_ctrl_t);
    localparam int QW = CTRL_W + 2 * AW + CW + 13;

    logic [12:0] ref_length_reg;
    logic [12:0] window_length_reg;
    logic [6:0]  kmer_length_reg;
    logic [1:0]  reg_index;
    logic        cfg_write;
    cfg_t        cfg;

    logic        init_done;
    logic        push;
    cmd_ctrl_t   push_ctrl;
    logic [AW-1:0] push_start;
    logic [AW-1:0] push_stop;
    logic [CW-1:0] push_nwin;
    logic [12:0]   push_win;
    logic        q_full;

    logic        q_valid;
    logic        q_pop;
    logic [QW-1:0] q_head;
    cmd_ctrl_t   q_ctrl;
    logic [AW-1:0] q_start;
    logic [AW-1:0] q_stop;
    logic [CW-1:0] q_nwin;
    logic [12:0]   q_win;

    // Register file: write on the access phase, zero-wait
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_length_reg    <= REF_LEN_RESET;
            window_length_reg <= WIN_LEN_RESET;
            kmer_length_reg   <= KMER_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_REF_LEN:  ref_length_reg    <= pwdata[12:0];
                REG_WIN_LEN:  window_length_reg <= pwdata[12:0];
                REG_KMER_LEN: kmer_length_reg   <= pwdata[6:0];
                default:      ;  // drop writes to unmapped offsets
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_REF_LEN:  prdata = DATA_W'(ref_length_reg);
            REG_WIN_LEN:  prdata = DATA_W'(window_length_reg);
            REG_KMER_LEN: prdata = DATA_W'(kmer_length_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.ref_length    = ref_length_reg;
    assign cfg.window_length = window_length_reg;
    assign cfg.kmer_length   = kmer_length_reg;

    // Front: accept a word, turn a hit into its window range
    kmhv_front #(
        .MAX_REF (MAX_REF)
    ) u_front (
        .cfg          (cfg),
        .init_done    (init_done),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .hit_position (hit_position),
        .q_full       (q_full),
        .push         (push),
        .push_ctrl    (push_ctrl),
        .push_start   (push_start),
        .push_stop    (push_stop),
        .push_nwin    (push_nwin),
        .push_win     (push_win)
    );

    // Short command queue decouples the front from the memory engine
    kmhv_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctrl, push_start, push_stop, push_nwin, push_win}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign {q_ctrl, q_start, q_stop, q_nwin, q_win} = q_head;

    // Back: difference-form vote store, scan and result register
    kmhv_back #(
        .MAX_REF   (MAX_REF),
        .VOTE_BITS (VOTE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .init_done    (init_done),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_ctrl       (q_ctrl),
        .q_start      (q_start),
        .q_stop       (q_stop),
        .q_nwin       (q_nwin),
        .q_win        (q_win),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_region  (best_region),
        .best_votes   (best_votes),
        .tied_regions (tied_regions),
        .region_len   (region_len)
    );

endmodule

// ===== rtl/kmhv_queue.sv =====
module kmhv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);
    import kmhv_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT  = NW'(QUEUE_DEPTH);

    logic [WIDTH-1:0] slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign valid = (count_reg != '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/kmhv_front.sv =====
module kmhv_front #(
    parameter int MAX_REF = 4096
) (
    input  kmhv_pkg::cfg_t                     cfg,
    input  logic                               init_done,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [11:0]                        hit_position,
    input  logic                               q_full,
    output logic                               push,
    output kmhv_pkg::cmd_ctrl_t                push_ctrl,
    output logic [$clog2(MAX_REF)-1:0]         push_start,
    output logic [$clog2(MAX_REF)-1:0]         push_stop,
    output logic [$clog2(MAX_REF+1)-1:0]       push_nwin,
    output logic [12:0]                        push_win
);
    import kmhv_pkg::*;

    localparam int AW = $clog2(MAX_REF);
    localparam int CW = $clog2(MAX_REF + 1);
    localparam int XW = ((CW > 13) ? CW : 13) + 1;
    localparam logic [XW-1:0] REF_LIMIT = XW'(MAX_REF);

    logic [XW-1:0] ref_x, win_x, kmer_x;
    logic [XW-1:0] r_eff, w_eff, k_eff, nwin;
    logic [XW-1:0] pos_x, reach, start, pos_next, stop;

    // Clamp the registers into a consistent set of lengths
    always_comb
    begin
        ref_x  = XW'(cfg.ref_length);
        win_x  = XW'(cfg.window_length);
        kmer_x = XW'(cfg.kmer_length);

        r_eff = ref_x;
        if (ref_x == '0)
        begin
            r_eff = XW'(1);
        end
        else if (ref_x > REF_LIMIT)
        begin
            r_eff = REF_LIMIT;
        end

        w_eff = win_x;
        if (win_x == '0)
        begin
            w_eff = XW'(1);
        end
        else if (win_x > r_eff)
        begin
            w_eff = r_eff;
        end

        k_eff = kmer_x;
        if (kmer_x == '0)
        begin
            k_eff = XW'(1);
        end
        else if (kmer_x > w_eff)
        begin
            k_eff = w_eff;
        end

        nwin = r_eff - w_eff + XW'(1);
    end

    // Range of windows that fully hold the k-mer: [start, stop)
    always_comb
    begin
        pos_x    = XW'(hit_position);
        reach    = pos_x + k_eff;
        start    = (reach > w_eff) ? (reach - w_eff) : '0;
        pos_next = pos_x + XW'(1);
        stop     = (pos_next > nwin) ? nwin : pos_next;
    end

    assign in_ready = init_done && !q_full;
    assign push     = in_valid && in_ready;

    assign push_ctrl.is_finish = (req_type == REQ_FINISH);
    assign push_ctrl.vote      = (start < stop);
    assign push_ctrl.end_valid = (stop < REF_LIMIT);
    assign push_start          = AW'(start);
    assign push_stop           = AW'(stop);
    assign push_nwin           = CW'(nwin);
    assign push_win            = 13'(w_eff);

endmodule

// ===== rtl/kmhv_back.sv =====
module kmhv_back #(
    parameter int MAX_REF   = 4096,
    parameter int VOTE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         init_done,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  kmhv_pkg::cmd_ctrl_t          q_ctrl,
    input  logic [$clog2(MAX_REF)-1:0]   q_start,
    input  logic [$clog2(MAX_REF)-1:0]   q_stop,
    input  logic [$clog2(MAX_REF+1)-1:0] q_nwin,
    input  logic [12:0]                  q_win,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [11:0]                  best_region,
    output logic [15:0]                  best_votes,
    output logic [12:0]                  tied_regions,
    output logic [12:0]                  region_len
);
    import kmhv_pkg::*;

    localparam int AW = $clog2(MAX_REF);
    localparam int CW = $clog2(MAX_REF + 1);
    localparam int DW = VOTE_BITS + 1;
    localparam int EW = VOTE_BITS + DW;
    localparam logic [AW-1:0]        LAST_ADDR = AW'(MAX_REF - 1);
    localparam logic [DW-1:0]        HIT_LIMIT = {1'b1, {VOTE_BITS{1'b0}}};
    localparam logic [VOTE_BITS-1:0] VOTE_MAX  = {VOTE_BITS{1'b1}};

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HIT_B = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_NORM  = 5'b10000
    } state_t;

    // Entry layout: {base count, difference}; count = min(base + prefix of diffs, max)
    logic [EW-1:0] mem [MAX_REF];

    state_t         state_reg, state_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [DW-1:0]  hits_reg, hits_next;
    logic [AW-1:0]  stop_reg, stop_next;
    logic [CW-1:0]  nwin_reg, nwin_next;
    logic [12:0]    win_reg, win_next;
    logic           pending_reg, pending_next;

    op_t            iss_op;
    logic [AW-1:0]  iss_addr;
    logic           rd_en;

    op_t            s1_op_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic           s1_first_reg;
    logic           s1_last_reg;
    logic [EW-1:0]  rd_data_reg;
    logic           fwd_reg;
    logic [EW-1:0]  fwd_data_reg;
    logic [DW-1:0]  prefix_reg;

    logic [EW-1:0]          rd_word;
    logic [VOTE_BITS-1:0]   cur_base;
    logic [DW-1:0]          cur_diff;
    logic [DW-1:0]          prefix_sum;
    logic [DW-1:0]          total;
    logic [VOTE_BITS-1:0]   sat_val;
    logic                   wr_en;
    logic [EW-1:0]          wr_data;

    logic                   s2_valid_reg;
    logic [VOTE_BITS-1:0]   s2_val_reg;
    logic [AW-1:0]          s2_addr_reg;
    logic                   s2_first_reg;
    logic                   s2_last_reg;

    logic [VOTE_BITS-1:0]   best_reg, best_next;
    logic [AW-1:0]          best_at_reg, best_at_next;
    logic [CW-1:0]          ties_reg, ties_next;
    logic                   in_win;

    logic                   out_valid_reg;
    logic [11:0]            best_region_reg;
    logic [15:0]            best_votes_reg;
    logic [12:0]            tied_regions_reg;
    logic [12:0]            region_len_reg;

    assign init_done = (state_reg != ST_INIT);

    // Sequencer: at most one memory operation issued per cycle
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hits_next    = hits_reg;
        stop_next    = stop_reg;
        nwin_next    = nwin_reg;
        win_next     = win_reg;
        pending_next = pending_reg;
        q_pop        = 1'b0;
        iss_op       = OP_NONE;
        iss_addr     = idx_reg;

        if (s2_valid_reg && s2_last_reg)
        begin
            pending_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                iss_op   = OP_ZERO;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                priority if (hits_reg == HIT_LIMIT)
                begin
                    state_next = ST_NORM;
                end
                else if (q_valid)
                begin
                    if (q_ctrl.is_finish)
                    begin
                        if (!pending_reg && !out_valid_reg)
                        begin
                            q_pop        = 1'b1;
                            nwin_next    = q_nwin;
                            win_next     = q_win;
                            pending_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    else
                    begin
                        q_pop = 1'b1;
                        if (q_ctrl.vote)
                        begin
                            iss_op    = OP_INC;
                            iss_addr  = q_start;
                            hits_next = hits_reg + 1'b1;
                            if (q_ctrl.end_valid)
                            begin
                                stop_next  = q_stop;
                                state_next = ST_HIT_B;
                            end
                        end
                    end
                end
            end
            ST_HIT_B:
            begin
                iss_op     = OP_DEC;
                iss_addr   = stop_reg;
                state_next = ST_IDLE;
            end
            ST_SCAN, ST_NORM:
            begin
                iss_op   = (state_reg == ST_SCAN) ? OP_SCAN : OP_NORM;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    hits_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                idx_next   = '0;
                state_next = ST_INIT;
            end
        endcase
    end

    assign rd_en = (iss_op != OP_NONE) && (iss_op != OP_ZERO);

    // Stage 1: data back from memory, modify and write
    always_comb
    begin
        rd_word    = fwd_reg ? fwd_data_reg : rd_data_reg;
        cur_base   = rd_word[EW-1:DW];
        cur_diff   = rd_word[DW-1:0];
        prefix_sum = (s1_first_reg ? '0 : prefix_reg) + cur_diff;
        total      = {1'b0, cur_base} + prefix_sum;
        sat_val    = total[VOTE_BITS] ? VOTE_MAX : total[VOTE_BITS-1:0];
        wr_en      = (s1_op_reg != OP_NONE);
        unique case (s1_op_reg)
            OP_INC:  wr_data = {cur_base, cur_diff + DW'(1)};
            OP_DEC:  wr_data = {cur_base, cur_diff - DW'(1)};
            OP_NORM: wr_data = {sat_val, {DW{1'b0}}};
            default: wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[iss_addr];
        end
    end

    // Stage 2: running maximum and tie count over the windows
    always_comb
    begin
        in_win       = (CW'(s2_addr_reg) < nwin_reg);
        best_next    = s2_first_reg ? '0 : best_reg;
        best_at_next = s2_first_reg ? '0 : best_at_reg;
        ties_next    = s2_first_reg ? '0 : ties_reg;
        if (in_win)
        begin
            if (s2_val_reg > best_next)
            begin
                best_next    = s2_val_reg;
                best_at_next = s2_addr_reg;
                ties_next    = CW'(1);
            end
            else if (s2_val_reg == best_next)
            begin
                ties_next = ties_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            hits_reg      <= '0;
            pending_reg   <= 1'b0;
            s1_op_reg     <= OP_NONE;
            fwd_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            hits_reg     <= hits_next;
            pending_reg  <= pending_next;
            s1_op_reg    <= iss_op;
            fwd_reg      <= rd_en && wr_en && (iss_addr == s1_addr_reg);
            s2_valid_reg <= (s1_op_reg == OP_SCAN);
            if (s2_valid_reg && s2_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg     <= stop_next;
        nwin_reg     <= nwin_next;
        win_reg      <= win_next;
        s1_addr_reg  <= iss_addr;
        s1_first_reg <= (idx_reg == '0);
        s1_last_reg  <= (idx_reg == LAST_ADDR);
        fwd_data_reg <= wr_data;
        if ((s1_op_reg == OP_SCAN) || (s1_op_reg == OP_NORM))
        begin
            prefix_reg <= prefix_sum;
        end
        s2_val_reg   <= sat_val;
        s2_addr_reg  <= s1_addr_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        if (s2_valid_reg)
        begin
            best_reg    <= best_next;
            best_at_reg <= best_at_next;
            ties_reg    <= ties_next;
        end
        if (s2_valid_reg && s2_last_reg)
        begin
            best_region_reg  <= 12'(best_at_next);
            best_votes_reg   <= 16'(best_next);
            tied_regions_reg <= 13'(ties_next);
            region_len_reg   <= win_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign best_region  = best_region_reg;
    assign best_votes   = best_votes_reg;
    assign tied_regions = tied_regions_reg;
    assign region_len   = region_len_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(pending_reg && out_valid_reg))
        else $error("finish pass running while a report still waits");

    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= HIT_LIMIT)
        else $error("vote count since normalization past its limit");

    a_report_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |-> pending_reg)
        else $error("report produced without a finish in progress");

    a_edge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HIT_B) |-> ($past(state_reg) == ST_IDLE))
        else $error("end edge issued without a start edge");

endmodule

// ===== test/kmer_hit_region_voter_tb.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kmhv_pkg::*;

    localparam int          MAX_REF       = MAX_REF_DEFAULT;
    localparam int          VOTE_BITS     = VOTE_BITS_DEFAULT;
    localparam int unsigned VOTE_MAX      = (1 << VOTE_BITS) - 1;
    // Address 0xC decodes to no register; writes there must change nothing
    localparam logic [1:0]  REG_SPARE     = 2'd3;
    // A finish walks the whole store and a fold may precede it
    localparam int          DRAIN_CYCLES  = 2 * MAX_REF + 64;
    // Longest legal quiet spell: fold + scan + a held result, with margin
    localparam int          STUCK_LIMIT   = 40000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_WORDS   = 200;
    // Length of the back-to-back stream that stacks votes on a few windows
    localparam int          STREAM_HITS   = 40;

    // One request word as the sender holds it
    typedef struct packed {
        logic        kind;
        logic [11:0] pos;
    } seed_word_t;

    // One finish report as the voter should return it
    typedef struct packed {
        logic [11:0] region;
        logic [15:0] votes;
        logic [12:0] ties;
        logic [12:0] span;
    } vote_report_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr  = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        req_type     = REQ_HIT;
    logic [11:0] hit_position = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [11:0] best_region;
    logic [15:0] best_votes;
    logic [12:0] tied_regions;
    logic [12:0] region_len;

    // Words waiting for the sender, and reports waiting for the voter
    seed_word_t   words_to_send [$];
    vote_report_t reports_due [$];

    // Shadow of the register file and of the vote store
    cfg_t        shadow = '{REF_LEN_RESET, WIN_LEN_RESET, KMER_LEN_RESET};
    int unsigned window_votes [MAX_REF];

    bit          took_req       = 1'b0;
    bit          steady         = 1'b0;
    int unsigned owed           = 0;
    int unsigned mismatches     = 0;
    int unsigned stalled_cycles = 0;
    int unsigned gap_left       = 0;
    int unsigned burst_left     = 1;
    int unsigned hold_left      = 0;

    always #2 clk = ~clk;

    kmer_hit_region_voter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .hit_position (hit_position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_region  (best_region),
        .best_votes   (best_votes),
        .tied_regions (tied_regions),
        .region_len   (region_len)
    );

    // Clamp the shadow registers the way the voter does: reference to
    // 1..MAX_REF, window to 1..reference, k-mer to 1..window.
    function automatic void effective_lengths(output int unsigned r,
                                              output int unsigned w,
                                              output int unsigned k);
        r = shadow.ref_length;
        if (r < 1) r = 1;
        if (r > MAX_REF) r = MAX_REF;
        w = shadow.window_length;
        if (w < 1) w = 1;
        if (w > r) w = r;
        k = shadow.kmer_length;
        if (k < 1) k = 1;
        if (k > w) k = w;
    endfunction

    // Add one vote to every window that fully holds the k-mer at pos.
    // Windows start no lower than 0 and stop at the last window; a k-mer
    // that runs off the reference end gets an empty range.
    function automatic void cast_votes(input logic [11:0] pos);
        int unsigned r, w, k, lo, hi, i;
        effective_lengths(r, w, k);
        lo = (pos + k > w) ? pos + k - w : 0;
        hi = pos + 1;
        if (hi > r - w + 1) hi = r - w + 1;
        for (i = lo; i < hi; i++)
            if (window_votes[i] < VOTE_MAX) window_votes[i]++;
    endfunction

    // Scan the windows of the current registers, queue the report, then
    // wipe the whole store for the next run.
    function automatic void tally_report();
        int unsigned r, w, k, nwin, top, top_at, ties, i;
        vote_report_t rep;
        effective_lengths(r, w, k);
        nwin   = r - w + 1;
        top    = 0;
        top_at = 0;
        ties   = 0;
        for (i = 0; i < nwin; i++)
        begin
            if (window_votes[i] > top)
            begin
                top    = window_votes[i];
                top_at = i;
            end
        end
        for (i = 0; i < nwin; i++)
            if (window_votes[i] == top) ties++;
        rep.region = top_at[11:0];
        rep.votes  = top[15:0];
        rep.ties   = ties[12:0];
        rep.span   = w[12:0];
        reports_due.push_back(rep);
        for (i = 0; i < MAX_REF; i++)
            window_votes[i] = 0;
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Sender: present the next word at the falling edge once the previous
    // one was taken. Hold valid and payload while the voter stalls; work in
    // bursts with gaps between them unless a steady stream is wanted.
    always @(negedge clk)
    begin
        seed_word_t word;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !took_req)
            ;
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (words_to_send.size() != 0)
        begin
            word = words_to_send.pop_front();
            in_valid     <= 1'b1;
            req_type     <= word.kind;
            hit_position <= word.pos;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 24);
                if (steady)
                    gap_left <= 0;
                else if ($urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(8, 40);
                else
                    gap_left <= $urandom_range(0, 5);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: alternate ready and stalled stretches of random length.
    // A rare very long stall outlasts a whole scan, so a second finish has
    // to wait behind the held report.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else
        begin
            out_ready <= !out_ready;
            if (out_ready)
                hold_left <= ($urandom_range(0, 2047) == 0) ? $urandom_range(4000, 9000)
                                                            : $urandom_range(0, 30);
            else
                hold_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(0, 40);
        end
    end

    // Predict on every accepted request word, check every accepted result
    // word against the oldest report due, and watch for a hang.
    always @(posedge clk)
    begin
        vote_report_t want;
        took_req <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            if (req_type == REQ_FINISH)
                tally_report();
            else
                cast_votes(hit_position);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t: report with none due: region %0d votes %0d ties %0d len %0d",
                         $time, best_region, best_votes, tied_regions, region_len);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                compare_field("best_region", want.region, best_region);
                compare_field("best_votes", want.votes, best_votes);
                compare_field("tied_regions", want.ties, tied_regions);
                compare_field("region_len", want.span, region_len);
            end
        end
        owed <= reports_due.size();
        // Count only while a word is offered or a report is owed
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && reports_due.size() == 0))
            stalled_cycles <= 0;
        else if (stalled_cycles == STUCK_LIMIT)
        begin
            $display("kmer_hit_region_voter regression: fail");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // Two-phase register write: setup, then access; the register takes the
    // value at the edge that ends the access phase.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_REF_LEN:  shadow.ref_length    = value[12:0];
            REG_WIN_LEN:  shadow.window_length = value[12:0];
            REG_KMER_LEN: shadow.kmer_length   = value[6:0];
            default: ;
        endcase
    endtask

    // Write all three lengths; junk in the unused upper bits must be dropped.
    task automatic program_lengths(input int unsigned ref_val, input int unsigned win_val,
                                   input int unsigned kmer_val);
        write_reg(REG_REF_LEN, {19'($urandom()), 13'(ref_val)});
        write_reg(REG_WIN_LEN, {19'($urandom()), 13'(win_val)});
        write_reg(REG_KMER_LEN, {25'($urandom()), 7'(kmer_val)});
    endtask

    function automatic void queue_hit(input logic [11:0] pos);
        words_to_send.push_back('{REQ_HIT, pos});
    endfunction

    function automatic void queue_finish();
        words_to_send.push_back('{REQ_FINISH, 12'($urandom())});
    endfunction

    // Wait until every word is taken and every report is back, then give
    // the back end time to finish a scan or fold that produces no word.
    task automatic settle();
        do
            @(posedge clk);
        while (words_to_send.size() != 0 || in_valid || owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly cluster hits around one spot so a clear winner forms; mix in
    // uniform noise and positions at both ends of the reference.
    function automatic logic [11:0] pick_position(input int unsigned center,
                                                  input int unsigned r,
                                                  input int unsigned w,
                                                  input int unsigned k);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 12'(center + $urandom_range(0, w) - w / 2);
            6, 7:             return 12'($urandom());
            8:                return 12'(r + $urandom_range(0, 4) - k - 2);
            default:          return 12'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic pick_config();
        int unsigned ref_val, win_val, kmer_val, r_eff, w_eff;
        case ($urandom_range(0, 5))
            0:       ref_val = $urandom_range(1, MAX_REF);
            1:       ref_val = $urandom_range(1, 64);
            2:       ref_val = MAX_REF;
            3:       ref_val = $urandom_range(0, 1) ? 0 : 8191;
            4:       ref_val = $urandom_range(0, 8191);
            default: ref_val = $urandom_range(64, 512);
        endcase
        r_eff = (ref_val == 0) ? 1 : ((ref_val > MAX_REF) ? MAX_REF : ref_val);
        case ($urandom_range(0, 4))
            0:       win_val = $urandom_range(0, 8191);
            1:       win_val = r_eff;
            default: win_val = $urandom_range(1, r_eff);
        endcase
        w_eff = (win_val == 0) ? 1 : ((win_val > r_eff) ? r_eff : win_val);
        if ($urandom_range(0, 4) == 0)
            kmer_val = $urandom_range(0, 127);
        else
            kmer_val = $urandom_range(1, (w_eff < 64) ? w_eff : 64);
        program_lengths(ref_val, win_val, kmer_val);
    endtask

    // Runs of hits closed by a finish; now and then leave a run open so its
    // votes carry across the next register change.
    task automatic fill_phase();
        int unsigned r, w, k, center, run, words;
        effective_lengths(r, w, k);
        words = 0;
        while (words < PHASE_WORDS)
        begin
            run    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4)
                                                 : $urandom_range(10, 50);
            center = $urandom_range(0, r - 1);
            repeat (run)
            begin
                queue_hit(pick_position(center, r, w, k));
                words++;
            end
            if ($urandom_range(0, 9) != 0)
            begin
                queue_finish();
                words++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset lengths: empty store first (every window ties at zero),
        // then hits at both ends, one running off the end, and repeats.
        @(posedge clk);
        queue_finish();
        queue_hit(12'd0);
        queue_hit(12'd0);
        queue_hit(12'd4095);
        queue_hit(12'd4081);
        queue_hit(12'd2048);
        queue_hit(12'd2048);
        queue_hit(12'd1000);
        queue_finish();
        settle();

        // Short reference: k-mers that just fit and just spill at the end
        program_lengths(100, 10, 3);
        @(posedge clk);
        queue_hit(12'd0);
        queue_hit(12'd5);
        queue_hit(12'd95);
        queue_hit(12'd97);
        queue_hit(12'd98);
        queue_hit(12'd99);
        settle();
        // Change the window under live votes and poke the unused address
        write_reg(REG_WIN_LEN, 32'd20);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        @(posedge clk);
        queue_finish();
        settle();

        // All-zero registers clamp to a single one-base window
        program_lengths(0, 0, 0);
        @(posedge clk);
        queue_hit(12'd0);
        queue_hit(12'd4095);
        queue_finish();
        settle();

        // All-ones registers clamp to the full reference, one window
        program_lengths(8191, 8191, 127);
        @(posedge clk);
        queue_hit(12'd0);
        queue_hit(12'd3969);
        queue_hit(12'd3970);
        queue_finish();
        settle();

        // Stack votes on four windows with one back-to-back stream
        program_lengths(8, 4, 1);
        @(posedge clk);
        steady = 1'b1;
        repeat (STREAM_HITS) queue_hit(12'd3);
        repeat (3) queue_hit(12'd7);
        queue_finish();
        settle();
        steady = 1'b0;

        repeat (RANDOM_PHASES)
        begin
            pick_config();
            @(posedge clk);
            fill_phase();
            settle();
        end

        if (mismatches == 0)
            $display("kmer_hit_region_voter regression: pass");
        else
            $display("kmer_hit_region_voter regression: fail");
        $finish;
    end

endmodule
